// ----- rtl/core/hmh_pkg.sv -----
`timescale 1ns / 1ps

package hmh_pkg;

   // fixed field widths of the channels and the register
   localparam int OP_W        = 2;
   localparam int HYB_IDX_W   = 1;
   localparam int CHIP_IDX_W  = 3;
   localparam int STRIP_IDX_W = 8;
   localparam int LEVEL_W     = 2;
   localparam int KIND_W      = 2;
   localparam int BIN_IDX_W   = 12;
   localparam int COUNT_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int MASK_W      = 16;

   // operation codes of an input item
   typedef enum logic [OP_W-1:0] {
      OP_HIT       = 2'd0,
      OP_END_EVENT = 2'd1,
      OP_READ      = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   // histogram levels
   localparam logic [LEVEL_W-1:0] LEVEL_CHIP   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_HYBRID = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MODULE = 2'd2;

   // histogram kinds, also the sub-step of one bump group
   localparam logic [KIND_W-1:0] KIND_ODD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EVEN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TOTAL = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_READ = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT   = 2'd2;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_ADDR,
      ST_RESULT,
      ST_W_DRAIN,
      ST_W_LOAD,
      ST_W_CHIP,
      ST_W_HYB,
      ST_W_MOD
   } state_type;

   // event counter memory commands
   typedef enum logic [1:0] {
      CNT_NONE,
      CNT_INC_ODD,
      CNT_INC_EVEN,
      CNT_DRAIN
   } cnt_op_type;

   // histogram memory commands
   typedef enum logic [1:0] {
      HIST_NONE,
      HIST_BUMP,
      HIST_READ,
      HIST_CLEAR
   } hist_op_type;

endpackage

// ----- rtl/core/hmh_req_if.sv -----
`timescale 1ns / 1ps

interface hmh_req_if;
   import hmh_pkg::*;

   logic                   valid;
   logic                   ready;
   op_type                 operation;
   logic [HYB_IDX_W-1:0]   hybrid_index;
   logic [CHIP_IDX_W-1:0]  chip_index;
   logic [STRIP_IDX_W-1:0] strip_index;
   logic [LEVEL_W-1:0]     histogram_level;
   logic [KIND_W-1:0]      histogram_kind;
   logic [BIN_IDX_W-1:0]   bin_index;

   modport source (
      output valid, operation, hybrid_index, chip_index, strip_index,
             histogram_level, histogram_kind, bin_index,
      input  ready
   );

   modport sink (
      input  valid, operation, hybrid_index, chip_index, strip_index,
             histogram_level, histogram_kind, bin_index,
      output ready
   );

endinterface

// ----- rtl/core/hmh_rsp_if.sv -----
`timescale 1ns / 1ps

interface hmh_rsp_if;
   import hmh_pkg::*;

   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  bin_count;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, bin_count, status,
      input  ready
   );

   modport sink (
      input  valid, bin_count, status,
      output ready
   );

endinterface

// ----- rtl/core/hmh_event_counters.sv -----
`timescale 1ns / 1ps

module hmh_event_counters #(
   parameter int STRIPS_PER_CHIP = 254,
   parameter int NUM_CHIPS       = 16,
   localparam int ODD_MAX  = STRIPS_PER_CHIP / 2,
   localparam int EVEN_MAX = (STRIPS_PER_CHIP + 1) / 2,
   localparam int CNT_W    = $clog2(EVEN_MAX + 1),
   localparam int G_W      = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hmh_pkg::cnt_op_type   cmd_op,
   input  logic [G_W-1:0]        cmd_addr,
   output logic [CNT_W-1:0]      drain_odd,
   output logic [CNT_W-1:0]      drain_even
);
   import hmh_pkg::*;

   localparam int WORD_W = 2 * CNT_W;

   logic [WORD_W-1:0]    mem [NUM_CHIPS];
   logic [NUM_CHIPS-1:0] valid_ff;
   logic [WORD_W-1:0]    q_ff;
   logic                 q_valid_ff;
   logic                 fwd_ff;
   logic [WORD_W-1:0]    fwd_word_ff;
   cnt_op_type           stage_op_ff;
   logic [G_W-1:0]       stage_addr_ff;

   logic [WORD_W-1:0]    cur_word;
   logic [CNT_W-1:0]     cur_odd;
   logic [CNT_W-1:0]     cur_even;
   logic                 wr_en;
   logic [WORD_W-1:0]    wr_word;

   // entry as read, with the write of the cycle before forwarded
   always_comb begin
      if (fwd_ff) begin
         cur_word = fwd_word_ff;
      end else if (q_valid_ff) begin
         cur_word = q_ff;
      end else begin
         cur_word = '0;
      end
   end

   assign cur_odd    = cur_word[WORD_W-1:CNT_W];
   assign cur_even   = cur_word[CNT_W-1:0];
   assign drain_odd  = cur_odd;
   assign drain_even = cur_even;

   // modify stage: saturating increment or drain to zero
   always_comb begin
      wr_en   = 1'b1;
      wr_word = cur_word;
      unique case (stage_op_ff)
         CNT_INC_ODD: begin
            if (cur_odd < CNT_W'(ODD_MAX)) begin
               wr_word = {cur_odd + CNT_W'(1), cur_even};
            end
         end
         CNT_INC_EVEN: begin
            if (cur_even < CNT_W'(EVEN_MAX)) begin
               wr_word = {cur_odd, cur_even + CNT_W'(1)};
            end
         end
         CNT_DRAIN: begin
            wr_word = '0;
         end
         CNT_NONE: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // memory array, read-first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[stage_addr_ff] <= wr_word;
      end
      if (cmd_op != CNT_NONE) begin
         q_ff <= mem[cmd_addr];
      end
   end

   // read stage payload
   always_ff @(posedge clock) begin
      if (cmd_op != CNT_NONE) begin
         fwd_word_ff   <= wr_word;
         stage_addr_ff <= cmd_addr;
      end
   end

   // entry valid bits and stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         q_valid_ff  <= 1'b0;
         fwd_ff      <= 1'b0;
         stage_op_ff <= CNT_NONE;
      end else begin
         if (wr_en) begin
            valid_ff[stage_addr_ff] <= 1'b1;
         end
         if (cmd_op != CNT_NONE) begin
            q_valid_ff <= valid_ff[cmd_addr];
            fwd_ff     <= wr_en && (stage_addr_ff == cmd_addr);
         end
         stage_op_ff <= cmd_op;
      end
   end

endmodule

// ----- rtl/core/hmh_histogram_store.sv -----
`timescale 1ns / 1ps

module hmh_histogram_store #(
   parameter int BIN_WIDTH = 32,
   parameter int DEPTH     = 36633,
   localparam int ADDR_W   = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hmh_pkg::hist_op_type  cmd_op,
   input  logic [ADDR_W-1:0]     cmd_addr,
   output logic [BIN_WIDTH-1:0]  rd_data
);
   import hmh_pkg::*;

   logic [BIN_WIDTH-1:0] mem [DEPTH];
   logic [BIN_WIDTH-1:0] q_ff;
   logic                 fwd_ff;
   logic [BIN_WIDTH-1:0] fwd_data_ff;
   logic                 bump_ff;
   logic [ADDR_W-1:0]    bump_addr_ff;

   logic                 rd_en;
   logic [BIN_WIDTH-1:0] cur;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [BIN_WIDTH-1:0] wr_data;

   assign rd_en   = (cmd_op == HIST_BUMP) || (cmd_op == HIST_READ);
   assign cur     = fwd_ff ? fwd_data_ff : q_ff;
   assign rd_data = cur;

   // write port: saturating bump has priority over a clearing write
   always_comb begin
      priority if (bump_ff) begin
         wr_en   = 1'b1;
         wr_addr = bump_addr_ff;
         wr_data = (cur == {BIN_WIDTH{1'b1}}) ? cur : cur + BIN_WIDTH'(1);
      end else if (cmd_op == HIST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = cmd_addr;
         wr_data = '0;
      end else begin
         wr_en   = 1'b0;
         wr_addr = cmd_addr;
         wr_data = '0;
      end
   end

   // memory array, read-first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[cmd_addr];
      end
   end

   // read stage payload, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff  <= wr_data;
         bump_addr_ff <= cmd_addr;
      end
   end

   // stage control and forwarding of a same-entry write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= 1'b0;
         bump_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            fwd_ff <= wr_en && (wr_addr == cmd_addr);
         end
         bump_ff <= (cmd_op == HIST_BUMP);
      end
   end

endmodule

// ----- rtl/core/hit_multiplicity_histogrammer_unit.sv -----
`timescale 1ns / 1ps
// channel  | dir | handshake        | payload
// req_ch   | in  | valid / ready    | operation, hybrid/chip/strip, level, kind, bin
// rsp_ch   | out | valid / ready    | bin_count, status
// csr_*    | in  | csr_wr_en        | csr_wr_data = chip_enable_mask
//
// a valid hit gives no result; a read passes the read-address and result states and a
// rejected hit the result state, one item at a time through the sequencer.
// end of event drains and loads each chip counter and bumps the histogram memory
// one bin a cycle: odd, even and total for each enabled chip, hybrid and the module.
// after reset and after each clear operation a clearing pass writes one bin a cycle
// over the whole store (36633 bins at default sizes); req ready is low meanwhile.
// a result waiting on rsp_ch stalls only a later read or rejected hit.

module hit_multiplicity_histogrammer_unit #(
   parameter int STRIPS_PER_CHIP  = 254,
   parameter int CHIPS_PER_HYBRID = 8,
   parameter int HYBRIDS          = 2,
   parameter int BIN_WIDTH        = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   hmh_req_if.sink                   req_ch,
   hmh_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [hmh_pkg::MASK_W-1:0] csr_wr_data
);
   import hmh_pkg::*;

   localparam int NUM_CHIPS  = HYBRIDS * CHIPS_PER_HYBRID;
   localparam int CHIP_BINS  = STRIPS_PER_CHIP + 1;
   localparam int HYB_BINS   = STRIPS_PER_CHIP * CHIPS_PER_HYBRID + 1;
   localparam int MOD_BINS   = STRIPS_PER_CHIP * NUM_CHIPS + 1;
   localparam int HYB_BASE   = NUM_CHIPS * 3 * CHIP_BINS;
   localparam int MOD_BASE   = HYB_BASE + HYBRIDS * 3 * HYB_BINS;
   localparam int STORE_SIZE = MOD_BASE + 3 * MOD_BINS;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int EVEN_MAX   = (STRIPS_PER_CHIP + 1) / 2;
   localparam int CNT_W      = $clog2(EVEN_MAX + 1);
   localparam int G_W        = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
   localparam int C_W        = (CHIPS_PER_HYBRID > 1) ? $clog2(CHIPS_PER_HYBRID) : 1;
   localparam int H_W        = (HYBRIDS > 1) ? $clog2(HYBRIDS) : 1;
   localparam int HV_W       = $clog2(HYB_BINS);
   localparam int MV_W       = $clog2(MOD_BINS);
   localparam int FIRST_FIXED_CHIP = 16;

   state_type               state_ff;
   state_type               state_in;

   logic [MASK_W-1:0]       mask_ff;
   logic [ADDR_W-1:0]       clr_addr_ff;
   logic [G_W-1:0]          walk_g_ff;
   logic [C_W-1:0]          walk_c_ff;
   logic [H_W-1:0]          walk_h_ff;
   logic [KIND_W-1:0]       walk_step_ff;
   logic [CNT_W-1:0]        chip_odd_ff;
   logic [CNT_W-1:0]        chip_even_ff;
   logic [HV_W-1:0]         hyb_odd_ff;
   logic [HV_W-1:0]         hyb_even_ff;
   logic [MV_W-1:0]         mod_odd_ff;
   logic [MV_W-1:0]         mod_even_ff;

   logic [HYB_IDX_W-1:0]    item_hyb_ff;
   logic [CHIP_IDX_W-1:0]   item_chip_ff;
   logic [LEVEL_W-1:0]      item_level_ff;
   logic [KIND_W-1:0]       item_kind_ff;
   logic [BIN_IDX_W-1:0]    item_bin_ff;
   logic [STATUS_W-1:0]     res_status_ff;
   logic                    res_mem_ff;

   logic                    rsp_valid_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   logic                    req_ready;
   logic                    req_xfer;
   logic                    out_free;
   logic                    hit_reject;
   logic [G_W-1:0]          hit_g;
   logic                    clear_last;
   logic                    chip_last;
   logic                    hyb_last;
   logic                    step_last;
   logic                    chip_en;
   logic [31:0]             walk_g_ext;
   logic [31:0]             bump_val;
   logic [31:0]             bump_addr32;
   logic [ADDR_W-1:0]       bump_addr;
   logic                    rd_ok;
   logic [31:0]             rd_addr32;
   logic [ADDR_W-1:0]       rd_addr;

   cnt_op_type              cnt_op;
   logic [G_W-1:0]          cnt_addr;
   logic [CNT_W-1:0]        drain_odd;
   logic [CNT_W-1:0]        drain_even;
   hist_op_type             hist_op;
   logic [ADDR_W-1:0]       hist_addr;
   logic [BIN_WIDTH-1:0]    hist_rd_data;

   // per-chip event counters
   hmh_event_counters #(
      .STRIPS_PER_CHIP (STRIPS_PER_CHIP),
      .NUM_CHIPS       (NUM_CHIPS)
   ) u_counters (
      .clock      (clock),
      .reset      (reset),
      .cmd_op     (cnt_op),
      .cmd_addr   (cnt_addr),
      .drain_odd  (drain_odd),
      .drain_even (drain_even)
   );

   // histogram bins
   hmh_histogram_store #(
      .BIN_WIDTH (BIN_WIDTH),
      .DEPTH     (STORE_SIZE)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd_op   (hist_op),
      .cmd_addr (hist_addr),
      .rd_data  (hist_rd_data)
   );

   // handshake and simple flags
   assign req_xfer   = req_ch.valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign hit_reject = (32'(req_ch.strip_index) >= 32'(STRIPS_PER_CHIP))
                    || (32'(req_ch.hybrid_index) >= 32'(HYBRIDS))
                    || (32'(req_ch.chip_index) >= 32'(CHIPS_PER_HYBRID));
   assign hit_g      = G_W'(32'(req_ch.hybrid_index) * 32'(CHIPS_PER_HYBRID)
                            + 32'(req_ch.chip_index));
   assign clear_last = (clr_addr_ff == ADDR_W'(STORE_SIZE - 1));
   assign chip_last  = (walk_c_ff == C_W'(CHIPS_PER_HYBRID - 1));
   assign hyb_last   = (walk_h_ff == H_W'(HYBRIDS - 1));
   assign step_last  = (walk_step_ff == KIND_TOTAL);
   assign walk_g_ext = 32'(walk_g_ff);
   assign chip_en    = (walk_g_ext >= 32'(FIRST_FIXED_CHIP)) || mask_ff[walk_g_ext[3:0]];

   // value bumped in the current walk step
   always_comb begin
      unique case (state_ff)
         ST_W_CHIP: begin
            unique case (walk_step_ff)
               KIND_ODD:  bump_val = 32'(chip_odd_ff);
               KIND_EVEN: bump_val = 32'(chip_even_ff);
               default:   bump_val = 32'(chip_odd_ff) + 32'(chip_even_ff);
            endcase
            bump_addr32 = walk_g_ext * 32'(3 * CHIP_BINS)
                        + 32'(walk_step_ff) * 32'(CHIP_BINS) + bump_val;
         end
         ST_W_HYB: begin
            unique case (walk_step_ff)
               KIND_ODD:  bump_val = 32'(hyb_odd_ff);
               KIND_EVEN: bump_val = 32'(hyb_even_ff);
               default:   bump_val = 32'(hyb_odd_ff) + 32'(hyb_even_ff);
            endcase
            bump_addr32 = 32'(HYB_BASE) + 32'(walk_h_ff) * 32'(3 * HYB_BINS)
                        + 32'(walk_step_ff) * 32'(HYB_BINS) + bump_val;
         end
         default: begin
            unique case (walk_step_ff)
               KIND_ODD:  bump_val = 32'(mod_odd_ff);
               KIND_EVEN: bump_val = 32'(mod_even_ff);
               default:   bump_val = 32'(mod_odd_ff) + 32'(mod_even_ff);
            endcase
            bump_addr32 = 32'(MOD_BASE) + 32'(walk_step_ff) * 32'(MOD_BINS) + bump_val;
         end
      endcase
   end

   assign bump_addr = bump_addr32[ADDR_W-1:0];

   // read address and range check of the held item
   always_comb begin
      logic kind_ok;
      kind_ok = (item_kind_ff == KIND_ODD) || (item_kind_ff == KIND_EVEN)
             || (item_kind_ff == KIND_TOTAL);
      unique case (item_level_ff)
         LEVEL_CHIP: begin
            rd_ok = kind_ok && (32'(item_hyb_ff) < 32'(HYBRIDS))
                 && (32'(item_chip_ff) < 32'(CHIPS_PER_HYBRID))
                 && (32'(item_bin_ff) < 32'(CHIP_BINS));
            rd_addr32 = (32'(item_hyb_ff) * 32'(CHIPS_PER_HYBRID) + 32'(item_chip_ff))
                          * 32'(3 * CHIP_BINS)
                      + 32'(item_kind_ff) * 32'(CHIP_BINS) + 32'(item_bin_ff);
         end
         LEVEL_HYBRID: begin
            rd_ok = kind_ok && (32'(item_hyb_ff) < 32'(HYBRIDS))
                 && (32'(item_bin_ff) < 32'(HYB_BINS));
            rd_addr32 = 32'(HYB_BASE) + 32'(item_hyb_ff) * 32'(3 * HYB_BINS)
                      + 32'(item_kind_ff) * 32'(HYB_BINS) + 32'(item_bin_ff);
         end
         LEVEL_MODULE: begin
            rd_ok = kind_ok && (32'(item_bin_ff) < 32'(MOD_BINS));
            rd_addr32 = 32'(MOD_BASE) + 32'(item_kind_ff) * 32'(MOD_BINS)
                      + 32'(item_bin_ff);
         end
         default: begin
            rd_ok     = 1'b0;
            rd_addr32 = '0;
         end
      endcase
   end

   assign rd_addr = rd_addr32[ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.operation)
                  OP_HIT:       state_in = hit_reject ? ST_RESULT : ST_IDLE;
                  OP_END_EVENT: state_in = ST_W_DRAIN;
                  OP_READ:      state_in = ST_RD_ADDR;
                  OP_CLEAR:     state_in = ST_CLEAR;
               endcase
            end
         end
         ST_RD_ADDR: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_W_DRAIN: state_in = ST_W_LOAD;
         ST_W_LOAD: begin
            if (chip_en) begin
               state_in = ST_W_CHIP;
            end else begin
               state_in = chip_last ? ST_W_HYB : ST_W_DRAIN;
            end
         end
         ST_W_CHIP: begin
            if (step_last) begin
               state_in = chip_last ? ST_W_HYB : ST_W_DRAIN;
            end
         end
         ST_W_HYB: begin
            if (step_last) begin
               state_in = hyb_last ? ST_W_MOD : ST_W_DRAIN;
            end
         end
         ST_W_MOD: begin
            if (step_last) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // sequencer outputs: ready and memory commands
   always_comb begin
      req_ready = 1'b0;
      cnt_op    = CNT_NONE;
      cnt_addr  = hit_g;
      hist_op   = HIST_NONE;
      hist_addr = bump_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            hist_op   = HIST_CLEAR;
            hist_addr = clr_addr_ff;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid && (req_ch.operation == OP_HIT) && !hit_reject) begin
               cnt_op = req_ch.strip_index[0] ? CNT_INC_ODD : CNT_INC_EVEN;
            end
         end
         ST_RD_ADDR: begin
            hist_addr = rd_addr;
            if (rd_ok) begin
               hist_op = HIST_READ;
            end
         end
         ST_RESULT: begin
         end
         ST_W_DRAIN: begin
            cnt_op   = CNT_DRAIN;
            cnt_addr = walk_g_ff;
         end
         ST_W_LOAD: begin
         end
         ST_W_CHIP, ST_W_HYB, ST_W_MOD: begin
            hist_op = HIST_BUMP;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mask_ff      <= {MASK_W{1'b1}};
         clr_addr_ff  <= '0;
         walk_g_ff    <= '0;
         walk_c_ff    <= '0;
         walk_h_ff    <= '0;
         walk_step_ff <= KIND_ODD;
         hyb_odd_ff   <= '0;
         hyb_even_ff  <= '0;
         mod_odd_ff   <= '0;
         mod_even_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         // clearing pass address
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clear_last ? '0 : clr_addr_ff + ADDR_W'(1);
         end
         // end of event walk position and sums
         unique case (state_ff)
            ST_W_LOAD: begin
               walk_step_ff <= KIND_ODD;
               if (chip_en) begin
                  hyb_odd_ff  <= hyb_odd_ff + HV_W'(drain_odd);
                  hyb_even_ff <= hyb_even_ff + HV_W'(drain_even);
               end else if (!chip_last) begin
                  walk_c_ff <= walk_c_ff + C_W'(1);
                  walk_g_ff <= walk_g_ff + G_W'(1);
               end
            end
            ST_W_CHIP: begin
               if (step_last) begin
                  walk_step_ff <= KIND_ODD;
                  if (!chip_last) begin
                     walk_c_ff <= walk_c_ff + C_W'(1);
                     walk_g_ff <= walk_g_ff + G_W'(1);
                  end
               end else begin
                  walk_step_ff <= walk_step_ff + KIND_W'(1);
               end
            end
            ST_W_HYB: begin
               if (step_last) begin
                  walk_step_ff <= KIND_ODD;
                  mod_odd_ff   <= mod_odd_ff + MV_W'(hyb_odd_ff);
                  mod_even_ff  <= mod_even_ff + MV_W'(hyb_even_ff);
                  hyb_odd_ff   <= '0;
                  hyb_even_ff  <= '0;
                  if (!hyb_last) begin
                     walk_h_ff <= walk_h_ff + H_W'(1);
                     walk_c_ff <= '0;
                     walk_g_ff <= walk_g_ff + G_W'(1);
                  end
               end else begin
                  walk_step_ff <= walk_step_ff + KIND_W'(1);
               end
            end
            ST_W_MOD: begin
               if (step_last) begin
                  walk_step_ff <= KIND_ODD;
                  mod_odd_ff   <= '0;
                  mod_even_ff  <= '0;
                  walk_g_ff    <= '0;
                  walk_c_ff    <= '0;
                  walk_h_ff    <= '0;
               end else begin
                  walk_step_ff <= walk_step_ff + KIND_W'(1);
               end
            end
            default: begin
            end
         endcase
         // output register valid
         if ((state_ff == ST_RESULT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_hyb_ff   <= req_ch.hybrid_index;
         item_chip_ff  <= req_ch.chip_index;
         item_level_ff <= req_ch.histogram_level;
         item_kind_ff  <= req_ch.histogram_kind;
         item_bin_ff   <= req_ch.bin_index;
      end
      // result source: rejected hit or read
      if (req_xfer && (req_ch.operation == OP_HIT)) begin
         res_status_ff <= STATUS_REJECT;
         res_mem_ff    <= 1'b0;
      end else if (state_ff == ST_RD_ADDR) begin
         res_status_ff <= rd_ok ? STATUS_OK : STATUS_BAD_READ;
         res_mem_ff    <= rd_ok;
      end
      if (state_ff == ST_W_LOAD) begin
         chip_odd_ff  <= drain_odd;
         chip_even_ff <= drain_even;
      end
      if ((state_ff == ST_RESULT) && out_free) begin
         rsp_count_ff  <= res_mem_ff ? COUNT_W'(hist_rd_data) : '0;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_ch.ready     = req_ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.bin_count = rsp_count_ff;
   assign rsp_ch.status    = rsp_status_ff;

endmodule

// ----- rtl/core/hmh_checker.sv -----
`timescale 1ns / 1ps

module hmh_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [hmh_pkg::COUNT_W-1:0]   rsp_bin_count,
   input  logic [hmh_pkg::STATUS_W-1:0]  rsp_status
);
   import hmh_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_count) && $stable(rsp_status))
      else $error("result changed while stalled");

   // only the defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_BAD_READ)
                    || (rsp_status == STATUS_REJECT))
      else $error("undefined status code");

   // an error result carries a zero count
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> (rsp_bin_count == '0))
      else $error("error result with nonzero count");

   // the clearing pass after reset takes no transfer
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input ready during clearing pass");

endmodule

bind hit_multiplicity_histogrammer_unit hmh_checker u_hmh_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_bin_count (rsp_ch.bin_count),
   .rsp_status    (rsp_ch.status)
);
